### rtl/core/rhc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhc_pkg
// Shared constants and types for the RGB/HSL color converter.
// ---------------------------------------------------------------------------
package rhc_pkg;

  // default number of fraction bits of the HSL values
  localparam int FRAC_BITS_DEF = 16;

  // divider lane width: remainders and divisors stay below 6*255+1
  localparam int DIV_W = 11;

  // divider lanes: hue and saturation
  localparam int DIV_LANES = 2;

  // direction register codes
  localparam logic DIR_TO_HSL = 1'b0;
  localparam logic DIR_TO_RGB = 1'b1;

  // hue sextant, counted from red
  typedef enum logic [2:0] {
    SEXT_R_TO_Y = 3'd0,
    SEXT_Y_TO_G = 3'd1,
    SEXT_G_TO_C = 3'd2,
    SEXT_C_TO_B = 3'd3,
    SEXT_B_TO_M = 3'd4,
    SEXT_M_TO_R = 3'd5
  } hue_sext_t;

endpackage

### rtl/core/rhc_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rhc_divider
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Each lane needs num <= den; the quotient is num * 2^(STEPS-1) / den.
// A side tag travels with each request.
// ---------------------------------------------------------------------------
module rhc_divider import rhc_pkg::*; #(
  parameter int STEPS = FRAC_BITS_DEF + 1,
  parameter int TAG_W = FRAC_BITS_DEF + 2
) (
  input  logic                            clk,
  input  logic [STEPS-1:0]                adv,
  input  logic [DIV_LANES-1:0][DIV_W-1:0] num_i,
  input  logic [DIV_LANES-1:0][DIV_W-1:0] den_i,
  input  logic [TAG_W-1:0]                tag_i,
  output logic [DIV_LANES-1:0][STEPS-1:0] quo_o,
  output logic [TAG_W-1:0]                tag_o
);

  logic [DIV_LANES-1:0][DIV_W-1:0] rem_r [STEPS];
  logic [DIV_LANES-1:0][DIV_W-1:0] den_r [STEPS];
  logic [DIV_LANES-1:0][STEPS-1:0] quo_r [STEPS];
  logic [TAG_W-1:0]                tag_r [STEPS];

  logic [DIV_LANES-1:0][DIV_W-1:0] rem_nxt [STEPS];
  logic [DIV_LANES-1:0][STEPS-1:0] quo_nxt [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [DIV_LANES-1:0][DIV_W:0]   rin;
    logic [DIV_LANES-1:0][DIV_W-1:0] dprev;
    logic [DIV_LANES-1:0][STEPS-1:0] qprev;
    logic [TAG_W-1:0]                tprev;

    if (s == 0) begin : g_first
      always_comb begin
        for (int ln = 0; ln < DIV_LANES; ln++) begin
          rin[ln] = {1'b0, num_i[ln]};
        end
        dprev = den_i;
        qprev = '0;
        tprev = tag_i;
      end
    end else begin : g_next
      always_comb begin
        for (int ln = 0; ln < DIV_LANES; ln++) begin
          rin[ln] = {rem_r[s-1][ln], 1'b0};
        end
        dprev = den_r[s-1];
        qprev = quo_r[s-1];
        tprev = tag_r[s-1];
      end
    end

    always_comb begin
      for (int ln = 0; ln < DIV_LANES; ln++) begin
        if (rin[ln] >= {1'b0, dprev[ln]}) begin
          rem_nxt[s][ln] = DIV_W'(rin[ln] - {1'b0, dprev[ln]});
          quo_nxt[s][ln] = {qprev[ln][STEPS-2:0], 1'b1};
        end else begin
          rem_nxt[s][ln] = rin[ln][DIV_W-1:0];
          quo_nxt[s][ln] = {qprev[ln][STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= dprev;
        quo_r[s] <= quo_nxt[s];
        tag_r[s] <= tprev;
      end
    end
  end

  assign quo_o = quo_r[STEPS-1];
  assign tag_o = tag_r[STEPS-1];

endmodule

### rtl/core/rgb_hsl_color_converter.sv
`timescale 1ns / 1ps
// Throughput: one pixel per cycle while out_tready is high;
// the bit-per-stage divider pipeline sets depth.
// Stalls propagate stage by stage, so empty stages still take new requests.
// Reset (rst_n low, synchronous) clears all valid bits and direction to rgb->hsl.
// ---------------------------------------------------------------------------
// rgb_hsl_color_converter
// Streaming per-pixel converter between 8-bit RGB and fixed-point HSL.
// ---------------------------------------------------------------------------
module rgb_hsl_color_converter import rhc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // in_first, in_second, in_third
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // out_first, out_second, out_third
);

  localparam int F     = FRAC_BITS;
  localparam int N     = F + 4;        // pipeline stages
  localparam int STEPS = F + 1;        // divider stages
  localparam int DLY   = F - 3;        // hsl->rgb result delay stages
  localparam int VW    = 2 * F + 1;
  localparam int PW    = 2 * F + 2;
  localparam int IW    = (F + 1 > 16) ? F + 1 : 16;
  localparam logic [15:0] FRAC_TOP = (F > 16) ? 16'hFFFF : 16'((1 << F) - 1);
  localparam logic [IW-1:0] ONE_I  = IW'(1) << F;
  // ceil(2^(F+16)/255): sum * 2^F / 510 by reciprocal, exact for sum <= 510
  localparam longint unsigned L_MUL = ((64'd1 << (F + 16)) + 64'd254) / 64'd255;

  // ---------------- control ----------------
  logic         dir_r;
  logic [N-1:0] valid_r, valid_nxt;
  logic [N:0]   adv;

  always_comb begin
    adv[N] = out_tready;
    for (int k = N - 1; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
    valid_nxt[0] = adv[0] ? in_tvalid : valid_r[0];
    for (int k = 1; k < N; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dir_r   <= DIR_TO_HSL;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        dir_r <= cfg_wdata;
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = valid_r[N-1];

  logic [15:0] f1, f2, f3;
  assign f1 = in_tdata[15:0];
  assign f2 = in_tdata[31:16];
  assign f3 = in_tdata[47:32];

  // ---------------- rgb -> hsl front ----------------
  logic [7:0] r0_r, g0_r, b0_r, mx0_r, d0_r;
  logic [8:0] sum0_r;
  logic [7:0] r_s, g_s, b_s, mx_s, mn_s;

  always_comb begin
    r_s  = (f1 > 16'd255) ? 8'd255 : f1[7:0];
    g_s  = (f2 > 16'd255) ? 8'd255 : f2[7:0];
    b_s  = (f3 > 16'd255) ? 8'd255 : f3[7:0];
    mx_s = r_s;
    mn_s = r_s;
    if (g_s > mx_s) mx_s = g_s;
    if (b_s > mx_s) mx_s = b_s;
    if (g_s < mn_s) mn_s = g_s;
    if (b_s < mn_s) mn_s = b_s;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r0_r   <= r_s;
      g0_r   <= g_s;
      b0_r   <= b_s;
      mx0_r  <= mx_s;
      d0_r   <= mx_s - mn_s;
      sum0_r <= {1'b0, mx_s} + {1'b0, mn_s};
    end
  end

  logic [DIV_LANES-1:0][DIV_W-1:0] dnum_r, dden_r, dnum_s, dden_s;
  logic                  grey1_r;
  logic [F:0]            lt1_r, lt_s;
  logic [F+17:0]         lprod_s;
  logic signed [11:0]    hn_s;
  logic [10:0]           d6_s;
  logic [8:0]            den_s;
  logic                  grey_s;

  always_comb begin
    grey_s = (d0_r == 8'd0);
    d6_s   = {1'b0, d0_r, 2'b00} + {2'b00, d0_r, 1'b0};
    den_s  = (sum0_r < 9'd255) ? sum0_r : 9'(10'd510 - {1'b0, sum0_r});
    if (r0_r == mx0_r) begin
      hn_s = $signed({4'b0, g0_r}) - $signed({4'b0, b0_r});
    end else if (g0_r == mx0_r) begin
      hn_s = $signed({3'b0, d0_r, 1'b0}) + $signed({4'b0, b0_r})
           - $signed({4'b0, r0_r});
    end else begin
      hn_s = $signed({2'b0, d0_r, 2'b0}) + $signed({4'b0, r0_r})
           - $signed({4'b0, g0_r});
    end
    if (hn_s < 0) hn_s = hn_s + $signed({1'b0, d6_s});
    dnum_s[0] = hn_s[DIV_W-1:0];
    dden_s[0] = grey_s ? DIV_W'(1) : d6_s;
    dnum_s[1] = DIV_W'(d0_r);
    dden_s[1] = grey_s ? DIV_W'(1) : DIV_W'(den_s);
    lprod_s   = (F+18)'(sum0_r) * (F+18)'(L_MUL);
    lt_s      = lprod_s[F+17:17];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dnum_r  <= dnum_s;
      dden_r  <= dden_s;
      grey1_r <= grey_s;
      lt1_r   <= lt_s;
    end
  end

  logic [DIV_LANES-1:0][STEPS-1:0] quo;
  logic [STEPS:0]        tag_q;
  logic                  grey_q;
  logic [STEPS-1:0]      lt_q;

  // lightness rides the divider as part of the tag
  rhc_divider #(.STEPS(STEPS), .TAG_W(STEPS + 1)) u_div (
    .clk   (clk),
    .adv   (adv[2 +: STEPS]),
    .num_i (dnum_r),
    .den_i (dden_r),
    .tag_i ({lt1_r, grey1_r}),
    .quo_o (quo),
    .tag_o (tag_q)
  );

  assign grey_q = tag_q[0];
  assign lt_q   = tag_q[STEPS:1];

  // ---------------- hsl -> rgb ----------------
  logic [F:0]      l_s, s_s;
  logic [F+2:0]    h6_s;
  logic [F:0]      l0_r, s0_r, l1_r, l2_r, l3_r;
  logic [PW-1:0]   ls0_r;
  hue_sext_t       sx0_r, sx1_r, sx2_r, sx3_r;
  logic [F-1:0]    fr0_r, fr1_r, fr2_r, fr3_r;

  always_comb begin
    l_s  = (IW'(f3) > ONE_I) ? ONE_I[F:0] : (F+1)'(IW'(f3));
    s_s  = (IW'(f2) > ONE_I) ? ONE_I[F:0] : (F+1)'(IW'(f2));
    h6_s = (F+3)'(IW'(f1) & (ONE_I - IW'(1))) * (F+3)'(6);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      l0_r  <= l_s;
      s0_r  <= s_s;
      ls0_r <= PW'(l_s) * PW'(s_s);
      sx0_r <= hue_sext_t'(h6_s[F+2:F]);
      fr0_r <= h6_s[F-1:0];
    end
  end

  logic [VW-1:0] v1_r, v2_r, m2_r, d2_r, v3_r, m3_r;
  logic [PW-1:0] lone_s, sone_s, vn_s, mn2_s;
  logic          half_s;

  always_comb begin
    lone_s = PW'(l0_r) << F;
    sone_s = PW'(s0_r) << F;
    half_s = ((F+2)'(l0_r) << 1) <= ((F+2)'(1) << F);
    vn_s   = half_s ? (lone_s + ls0_r) : (lone_s + sone_s - ls0_r);
    mn2_s  = (PW'(l1_r) << (F + 1)) - PW'(v1_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      v1_r  <= vn_s[VW-1:0];
      l1_r  <= l0_r;
      sx1_r <= sx0_r;
      fr1_r <= fr0_r;
    end
    if (adv[2]) begin
      v2_r  <= v1_r;
      m2_r  <= mn2_s[VW-1:0];
      d2_r  <= v1_r - mn2_s[VW-1:0];
      l2_r  <= l1_r;
      sx2_r <= sx1_r;
      fr2_r <= fr1_r;
    end
  end

  logic [VW-1:0]  p1_r;
  logic [2*F-1:0] p2_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      p1_r  <= VW'(d2_r[VW-1:F]) * VW'(fr2_r);
      p2_r  <= (2*F)'(d2_r[F-1:0]) * (2*F)'(fr2_r);
      v3_r  <= v2_r;
      m3_r  <= m2_r;
      l3_r  <= l2_r;
      sx3_r <= sx2_r;
      fr3_r <= fr2_r;
    end
  end

  logic [VW-1:0] vsf_s, mid1_s, mid2_s, rr_s, gg_s, bb_s;
  logic [VW-1:0] rr4_r, gg4_r, bb4_r;

  always_comb begin
    vsf_s  = p1_r + VW'(p2_r[2*F-1:F]);
    mid1_s = m3_r + vsf_s;
    mid2_s = v3_r - vsf_s;
    rr_s   = VW'(l3_r) << F;
    gg_s   = VW'(l3_r) << F;
    bb_s   = VW'(l3_r) << F;
    if (v3_r != '0) begin
      case (sx3_r)
        SEXT_R_TO_Y: begin rr_s = v3_r;   gg_s = mid1_s; bb_s = m3_r;   end
        SEXT_Y_TO_G: begin rr_s = mid2_s; gg_s = v3_r;   bb_s = m3_r;   end
        SEXT_G_TO_C: begin rr_s = m3_r;   gg_s = v3_r;   bb_s = mid1_s; end
        SEXT_C_TO_B: begin rr_s = m3_r;   gg_s = mid2_s; bb_s = v3_r;   end
        SEXT_B_TO_M: begin rr_s = mid1_s; gg_s = m3_r;   bb_s = v3_r;   end
        default:     begin rr_s = v3_r;   gg_s = m3_r;   bb_s = mid2_s; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rr4_r <= rr_s;
      gg4_r <= gg_s;
      bb4_r <= bb_s;
    end
  end

  // floor(x * 255) with 2F fraction bits, capped at 255
  function automatic logic [7:0] chan(input logic [VW-1:0] x);
    logic [VW+7:0] p;
    logic [8:0]    c;
    p = ((VW+8)'(x) << 8) - (VW+8)'(x);
    c = p[VW+7:2*F];
    return (c > 9'd255) ? 8'd255 : c[7:0];
  endfunction

  logic [23:0] ch5_r;
  logic [23:0] hsl_dly_r [DLY];

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ch5_r <= {chan(bb4_r), chan(gg4_r), chan(rr4_r)};
    end
    for (int k = 0; k < DLY; k++) begin
      if (adv[6+k]) begin
        hsl_dly_r[k] <= (k == 0) ? ch5_r : hsl_dly_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // ---------------- output stage ----------------
  function automatic logic [15:0] sat_frac(input logic [STEPS-1:0] q);
    return (q > STEPS'(FRAC_TOP)) ? FRAC_TOP : 16'(q);
  endfunction

  logic [47:0] out_data_r, out_s;

  always_comb begin
    if (dir_r == DIR_TO_RGB) begin
      out_s = {8'd0, hsl_dly_r[DLY-1][23:16], 8'd0, hsl_dly_r[DLY-1][15:8],
               8'd0, hsl_dly_r[DLY-1][7:0]};
    end else begin
      out_s[15:0]  = grey_q ? 16'd0 : sat_frac(quo[0]);
      out_s[31:16] = grey_q ? 16'd0 : sat_frac(quo[1]);
      out_s[47:32] = sat_frac(lt_q);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[N-1]) begin
      out_data_r <= out_s;
    end
  end

  assign out_tdata = out_data_r;

  // ---------------- assertions ----------------
  // requests in flight change only by what enters and leaves
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) ==
      $countones($past(valid_r)) + ($past(in_tvalid && in_tready) ? 1 : 0)
      - ($past(out_tvalid && out_tready) ? 1 : 0)))
    else $error("pipeline occupancy mismatch");

  // a taken output always frees room for a new request
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // rgb results are bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && dir_r == DIR_TO_RGB) |->
      (out_tdata[15:8] == 8'd0 && out_tdata[31:24] == 8'd0 && out_tdata[47:40] == 8'd0))
    else $error("rgb channel exceeds a byte");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB/HSL color converter testbench
// Streams pixels through the converter in both directions, predicts each
// result with an integer model of the conversion and compares field by
// field, under random source gaps and sink stalls.
// ---------------------------------------------------------------------------
module testbench import rhc_pkg::*; ();

  localparam int FB      = 16;
  localparam int LATENCY = FB + 4;
  localparam longint ONE = 64'd1 << FB;
  localparam int LIMIT   = 400000;
  localparam int HOLD_LEN = 3 * LATENCY;

  typedef struct packed {
    logic [15:0] third;
    logic [15:0] second;
    logic [15:0] first;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  rgb_hsl_color_converter uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  pixel_t pending_px[$];
  pixel_t expected_px[$];
  logic   dir_model;
  int     src_idle_pct;
  int     sink_stall_pct;
  logic   hold_go = 1'b0;
  logic   hold_active;
  int     errors = 0;
  int     cycle_cnt = 0;

  function automatic longint clamp_byte(longint x);
    return (x > 255) ? 255 : x;
  endfunction

  function automatic longint clamp_frac(longint x);
    return (x > ONE - 1) ? ONE - 1 : x;
  endfunction

  function automatic pixel_t rgb_to_hsl(pixel_t p);
    longint r, g, b, mx, mn, d, sum, num, den, h, s, l;
    pixel_t res;
    r = clamp_byte(p.first);
    g = clamp_byte(p.second);
    b = clamp_byte(p.third);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    l = (sum * ONE) / 510;
    h = 0; s = 0;
    if (d != 0) begin
      den = (sum < 255) ? sum : (510 - sum);
      s = (d * ONE) / den;
      if (r == mx) num = g - b;
      else if (g == mx) num = 2 * d + (b - r);
      else num = 4 * d + (r - g);
      if (num < 0) num += 6 * d;
      h = (num * ONE) / (6 * d);
    end
    res.first  = clamp_frac(h);
    res.second = clamp_frac(s);
    res.third  = clamp_frac(l);
    return res;
  endfunction

  function automatic logic [15:0] to_byte(logic [63:0] x);
    logic [95:0] prod;
    prod = x * 96'd255;
    prod = prod >> (2 * FB);
    return (prod > 255) ? 16'd255 : prod[15:0];
  endfunction

  function automatic pixel_t hsl_to_rgb(pixel_t p);
    logic [63:0] hue, s, l, v, m, d, h6, fract, vsf, mid1, mid2, rr, gg, bb;
    hue_sext_t sext;
    pixel_t res;
    hue = p.first & (ONE - 1);
    s = (p.second > ONE) ? ONE : p.second;
    l = (p.third > ONE) ? ONE : p.third;
    if (2 * l <= ONE) v = l * (ONE + s);
    else v = l * ONE + s * ONE - l * s;
    rr = l * ONE; gg = rr; bb = rr;
    if (v > 0) begin
      m = 2 * l * ONE - v;
      d = v - m;
      h6 = hue * 6;
      sext = hue_sext_t'(h6 >> FB);
      fract = h6 & (ONE - 1);
      vsf = (d >> FB) * fract + (((d & (ONE - 1)) * fract) >> FB);
      mid1 = m + vsf;
      mid2 = v - vsf;
      case (sext)
        SEXT_R_TO_Y: begin rr = v;    gg = mid1; bb = m;    end
        SEXT_Y_TO_G: begin rr = mid2; gg = v;    bb = m;    end
        SEXT_G_TO_C: begin rr = m;    gg = v;    bb = mid1; end
        SEXT_C_TO_B: begin rr = m;    gg = mid2; bb = v;    end
        SEXT_B_TO_M: begin rr = mid1; gg = m;    bb = v;    end
        default:     begin rr = v;    gg = m;    bb = mid2; end
      endcase
    end
    res.first  = to_byte(rr);
    res.second = to_byte(gg);
    res.third  = to_byte(bb);
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_px.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        pixel_t nxt;
        nxt = pending_px.pop_front();
        in_tdata  <= nxt;
        in_tvalid <= 1'b1;
        expected_px.push_back((dir_model == DIR_TO_RGB) ? hsl_to_rgb(nxt) : rgb_to_hsl(nxt));
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long sink hold-off, counted here once the sequence asks for it
  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_active <= 1'b0;
  end

  // sink: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_active) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pixel_t got, exp_px;
      got = out_tdata;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_px = expected_px.pop_front();
        if (got.first !== exp_px.first)
          $display("%0t: first exp %h got %h", $time, exp_px.first, got.first);
        if (got.second !== exp_px.second)
          $display("%0t: second exp %h got %h", $time, exp_px.second, got.second);
        if (got.third !== exp_px.third)
          $display("%0t: third exp %h got %h", $time, exp_px.third, got.third);
        if (got !== exp_px) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (pending_px.size() > 0 || in_tvalid || expected_px.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_direction(logic dir);
    cfg_we    <= 1'b1;
    cfg_wdata <= dir;
    dir_model = dir;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(logic dir);
    pixel_t p;
    int k;
    k = $urandom_range(9);
    if (dir == DIR_TO_HSL) begin
      p.first  = (k == 0) ? 16'($urandom) : 16'($urandom_range(255));
      p.second = (k == 1) ? 16'($urandom) : 16'($urandom_range(255));
      p.third  = (k == 2) ? 16'($urandom) : 16'($urandom_range(255));
      if (k == 3) begin p.second = p.first; p.third = p.first; end
    end else begin
      p = {16'($urandom), 16'($urandom), 16'($urandom)};
      if (k == 4) p.second = 16'($urandom_range(0, 3)) << 14;
      if (k == 5) p.third  = 16'($urandom_range(0, 3)) << 14;
    end
    return p;
  endfunction

  task automatic random_phase(logic dir, int n, int idle, int stall);
    src_idle_pct = idle;
    sink_stall_pct = stall;
    repeat (n) pending_px.push_back(rand_pixel(dir));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_tdata = '0;
    dir_model = DIR_TO_HSL;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, rgb to hsl: extremes, greys, each max channel, over-range
    pending_px.push_back('{16'd0, 16'd0, 16'd0});
    pending_px.push_back('{16'd255, 16'd255, 16'd255});
    pending_px.push_back('{16'd128, 16'd128, 16'd128});
    pending_px.push_back('{16'd0, 16'd0, 16'd255});
    pending_px.push_back('{16'd0, 16'd255, 16'd0});
    pending_px.push_back('{16'd255, 16'd0, 16'd0});
    pending_px.push_back('{16'd0, 16'd255, 16'd255});
    pending_px.push_back('{16'd255, 16'd10, 16'd200});
    pending_px.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_px.push_back('{16'h0100, 16'd3, 16'hFFFF});
    drain();

    set_direction(DIR_TO_RGB);
    // directed, hsl to rgb: zero lightness, full values, hue wrap, saturation
    pending_px.push_back('{16'd0, 16'd0, 16'd0});
    pending_px.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_px.push_back('{16'h8000, 16'hFFFF, 16'h0000});
    pending_px.push_back('{16'h8000, 16'h0000, 16'hFFFF});
    pending_px.push_back('{16'h8000, 16'h8000, 16'h4000});
    pending_px.push_back('{16'h8000, 16'h8000, 16'hC000});
    pending_px.push_back('{16'h8000, 16'h0000, 16'h2AAB});
    pending_px.push_back('{16'h8000, 16'h8000, 16'h5555});
    pending_px.push_back('{16'h8000, 16'h8000, 16'h8000});
    pending_px.push_back('{16'h8000, 16'h8000, 16'hAAAA});
    pending_px.push_back('{16'h8000, 16'h8000, 16'hD555});
    pending_px.push_back('{16'hFFFF, 16'h8000, 16'hFFFF});
    drain();

    random_phase(DIR_TO_RGB, 200, 0, 0);
    set_direction(DIR_TO_HSL);
    random_phase(DIR_TO_HSL, 200, 0, 0);
    random_phase(DIR_TO_HSL, 150, 78, 0);
    set_direction(DIR_TO_RGB);
    random_phase(DIR_TO_RGB, 150, 0, 78);
    random_phase(DIR_TO_RGB, 150, 23, 23);
    set_direction(DIR_TO_HSL);
    random_phase(DIR_TO_HSL, 150, 23, 23);

    // long sink hold-off while the source keeps offering: pipeline fills up
    src_idle_pct = 0;
    sink_stall_pct = 10;
    hold_go = 1'b1;
    repeat (150) pending_px.push_back(rand_pixel(DIR_TO_HSL));
    drain();
    set_direction(DIR_TO_RGB);
    random_phase(DIR_TO_RGB, 150, 40, 40);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
